FILE: rtl/serial_frame_level_display_assert.svh
// assertion macros shared by the serial frame level display modules
`ifndef SERIAL_FRAME_LEVEL_DISPLAY_ASSERT_SVH
`define SERIAL_FRAME_LEVEL_DISPLAY_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define SFLD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define SFLD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/sfld_pkg.sv
// shared types, constants and segment decode for the serial frame level display
package sfld_pkg;

  // frame buffer geometry
  localparam int FRAME_DEPTH = 64;
  localparam int IDX_W       = $clog2(FRAME_DEPTH);
  localparam int POS_W       = 6;
  localparam int CMP_W       = (IDX_W > POS_W) ? IDX_W : POS_W;
  localparam logic [IDX_W-1:0] LAST_INDEX = IDX_W'(FRAME_DEPTH - 1);

  // character and digit codes
  localparam logic [7:0] CHAR_ZERO  = 8'd48;
  localparam logic [7:0] CHAR_NINE  = 8'd57;
  localparam logic [3:0] BLANK_CODE = 4'd10;
  localparam logic [3:0] MAX_DIGIT  = 4'd9;
  localparam logic [6:0] SEG_BLANK  = 7'h7F;
  localparam logic [7:0] TICK_MAX   = 8'hFF;

  // configuration port
  localparam int CFG_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_END_MARKER      = 3'd0,
    CFG_BYTE_OFFSET     = 3'd1,
    CFG_TENS_POSITION   = 3'd2,
    CFG_ONES_POSITION   = 3'd3,
    CFG_LEVEL_THRESHOLD = 3'd4,
    CFG_TIMEOUT_TICKS   = 3'd5
  } sfld_cfg_idx_t;

  // item kinds on the input channel
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  typedef struct packed {
    logic [7:0]       end_marker;
    logic [7:0]       byte_offset;
    logic [POS_W-1:0] tens_position;
    logic [POS_W-1:0] ones_position;
    logic [6:0]       level_threshold;
    logic [7:0]       timeout_ticks;
  } sfld_cfg_t;

  // classified item passed from front to back
  typedef struct packed {
    logic       is_tick;
    logic       is_marker;
    logic [7:0] char_value;
  } sfld_item_t;

  // active-low segments a..g, bit0 is a
  function automatic logic [6:0] seg_of(input logic [3:0] code);
    logic [6:0] seg;
    unique case (code)
      4'd0:    seg = 7'h40;
      4'd1:    seg = 7'h79;
      4'd2:    seg = 7'h24;
      4'd3:    seg = 7'h30;
      4'd4:    seg = 7'h19;
      4'd5:    seg = 7'h12;
      4'd6:    seg = 7'h02;
      4'd7:    seg = 7'h78;
      4'd8:    seg = 7'h00;
      4'd9:    seg = 7'h10;
      default: seg = SEG_BLANK;
    endcase
    return seg;
  endfunction

endpackage

FILE: rtl/serial_frame_level_display.sv
// top level: configuration registers and front, queue and back end
//
// Serial frame level display. Input items arrive on in_valid/in_stall with
// in_opcode (0 received byte, 1 timer tick) and in_byte_value. Bytes fill a
// frame up to the end marker, which decodes two ASCII digits into a level;
// ticks drive a blink phase and a staleness timeout. Every accepted item
// gives one result on out_valid/out_stall: active-low segment patterns for
// both digits, display enable, level, stale flag and blink phase.
// Throughput is one item per cycle while out_stall is low; an accepted item
// passes through the two-entry queue and then the result register before
// its result can be transferred out.
// When out_stall is high the result holds, the back end stops popping and
// in_stall rises once the two queue entries are filled.
// Reset (rst_n low, synchronous) empties the queue and result register and
// loads the register defaults: end marker 141, offset 128, positions 59 and
// 60, threshold 82, timeout 2. The user must write registers via cfg_we,
// cfg_index and cfg_wdata only while the block is idle; it does not check this.
module serial_frame_level_display (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_opcode,
  input  logic [7:0] in_byte_value,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [6:0] out_tens_segments,
  output logic [6:0] out_ones_segments,
  output logic       out_display_on,
  output logic [6:0] out_level,
  output logic       out_stale,
  output logic       out_blink_phase
);
  import sfld_pkg::*;

  sfld_cfg_t  cfg_r, cfg_nxt;
  sfld_item_t push_item, q_item;
  logic       q_full, q_push, q_pop, q_valid;

  // configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (sfld_cfg_idx_t'(cfg_index))
        CFG_END_MARKER:      cfg_nxt.end_marker      = cfg_wdata;
        CFG_BYTE_OFFSET:     cfg_nxt.byte_offset     = cfg_wdata;
        CFG_TENS_POSITION:   cfg_nxt.tens_position   = cfg_wdata[POS_W-1:0];
        CFG_ONES_POSITION:   cfg_nxt.ones_position   = cfg_wdata[POS_W-1:0];
        CFG_LEVEL_THRESHOLD: cfg_nxt.level_threshold = cfg_wdata[6:0];
        CFG_TIMEOUT_TICKS:   cfg_nxt.timeout_ticks   = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.end_marker      <= 8'd141;
      cfg_r.byte_offset     <= 8'd128;
      cfg_r.tens_position   <= POS_W'(59);
      cfg_r.ones_position   <= POS_W'(60);
      cfg_r.level_threshold <= 7'd82;
      cfg_r.timeout_ticks   <= 8'd2;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // accept and classify
  sfld_front u_front (
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_opcode     (in_opcode),
    .in_byte_value (in_byte_value),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (push_item)
  );

  // decoupling queue
  sfld_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  // state update and result register
  sfld_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tens_segments (out_tens_segments),
    .out_ones_segments (out_ones_segments),
    .out_display_on    (out_display_on),
    .out_level         (out_level),
    .out_stale         (out_stale),
    .out_blink_phase   (out_blink_phase)
  );

endmodule

FILE: rtl/sfld_front.sv
// front end: accepts input transfers and classifies them for the queue
module sfld_front (
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_opcode,
  input  logic [7:0]         in_byte_value,
  input  sfld_pkg::sfld_cfg_t cfg,
  input  logic               q_full,
  output logic               q_push,
  output sfld_pkg::sfld_item_t q_item
);
  import sfld_pkg::*;

  // accept whenever the queue has room
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // classify: tick, end marker or stored character with offset removed
  always_comb begin
    q_item.is_tick    = (in_opcode == OP_TICK);
    q_item.is_marker  = (in_opcode == OP_BYTE) && (in_byte_value == cfg.end_marker);
    q_item.char_value = in_byte_value - cfg.byte_offset;
  end

endmodule

FILE: rtl/sfld_queue.sv
// two-entry queue between the front end and the back end
module sfld_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  sfld_pkg::sfld_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 q_valid,
  output sfld_pkg::sfld_item_t q_item
);
  import sfld_pkg::*;

  localparam logic [1:0] DEPTH = 2'd2;

  sfld_item_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;

  assign full    = (count_r == DEPTH);
  assign q_valid = (count_r != 2'd0);
  assign q_item  = entry_r[rd_ptr_r];

  // pointer and fill count update
  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 2'd1;
    end else if (pop && !push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

  `include "serial_frame_level_display_assert.svh"

  `SFLD_ASSERT(a_q_bound, count_r <= DEPTH, "queue fill count beyond depth")
  `SFLD_ASSERT_NEXT(a_q_grow, push && !pop, count_r == $past(count_r) + 2'd1, "queue did not grow")
  `SFLD_ASSERT_NEXT(a_q_shrink, pop && !push, count_r == $past(count_r) - 2'd1, "queue did not shrink")
  `SFLD_ASSERT(a_q_ptr, (count_r == 2'd1) == (wr_ptr_r != rd_ptr_r), "pointers disagree with count")

endmodule

FILE: rtl/sfld_back.sv
// back end: frame state, digit decode, timeout, blink and result register
module sfld_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sfld_pkg::sfld_cfg_t  cfg,
  input  logic                 q_valid,
  input  sfld_pkg::sfld_item_t q_item,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [6:0]           out_tens_segments,
  output logic [6:0]           out_ones_segments,
  output logic                 out_display_on,
  output logic [6:0]           out_level,
  output logic                 out_stale,
  output logic                 out_blink_phase
);
  import sfld_pkg::*;

  logic [IDX_W-1:0] byte_index_r, byte_index_nxt;
  logic [7:0]       tens_char_r, tens_char_nxt;
  logic [7:0]       ones_char_r, ones_char_nxt;
  logic [3:0]       tens_code_r, tens_code_nxt;
  logic [3:0]       ones_code_r, ones_code_nxt;
  logic [6:0]       level_r, level_nxt;
  logic [7:0]       tick_count_r, tick_count_nxt;
  logic             phase_r, phase_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic [6:0]       out_tens_seg_r, out_ones_seg_r, out_level_r;
  logic             out_on_r, out_stale_r, out_phase_r;

  logic             tens_digit, ones_digit;
  logic [3:0]       tens_dec, ones_dec;
  logic [6:0]       tens_x10;
  logic [7:0]       tick_inc;
  logic             stale_nxt, on_nxt;

  // take the next item when the result register is free or draining
  assign q_pop = q_valid && (!out_valid_r || !out_stall);

  // digit decode of the stored characters
  always_comb begin
    tens_digit = (tens_char_r >= CHAR_ZERO) && (tens_char_r <= CHAR_NINE);
    ones_digit = (ones_char_r >= CHAR_ZERO) && (ones_char_r <= CHAR_NINE);
    tens_dec   = 4'(tens_char_r - CHAR_ZERO);
    ones_dec   = 4'(ones_char_r - CHAR_ZERO);
    tens_x10   = ({3'b000, tens_dec} << 3) + ({3'b000, tens_dec} << 1);
    tick_inc   = (tick_count_r != TICK_MAX) ? tick_count_r + 8'd1 : tick_count_r;
  end

  // state update for one item
  always_comb begin
    byte_index_nxt = byte_index_r;
    tens_char_nxt  = tens_char_r;
    ones_char_nxt  = ones_char_r;
    tens_code_nxt  = tens_code_r;
    ones_code_nxt  = ones_code_r;
    level_nxt      = level_r;
    tick_count_nxt = tick_count_r;
    phase_nxt      = phase_r;
    if (q_pop) begin
      if (q_item.is_tick) begin
        phase_nxt      = !phase_r;
        tick_count_nxt = tick_inc;
        if (tick_inc > cfg.timeout_ticks) begin
          tens_code_nxt = BLANK_CODE;
          ones_code_nxt = BLANK_CODE;
        end
      end else begin
        tick_count_nxt = 8'd0;
        if (q_item.is_marker) begin
          tens_code_nxt  = tens_digit ? tens_dec : BLANK_CODE;
          ones_code_nxt  = ones_digit ? ones_dec : BLANK_CODE;
          if (tens_digit && ones_digit) begin
            level_nxt = tens_x10 + {3'b000, ones_dec};
          end
          byte_index_nxt = '0;
        end else if (byte_index_r < LAST_INDEX) begin
          if (CMP_W'(byte_index_r) == CMP_W'(cfg.tens_position)) begin
            tens_char_nxt = q_item.char_value;
          end
          if (CMP_W'(byte_index_r) == CMP_W'(cfg.ones_position)) begin
            ones_char_nxt = q_item.char_value;
          end
          byte_index_nxt = byte_index_r + IDX_W'(1);
        end
      end
    end
  end

  // result fields from the updated state
  always_comb begin
    stale_nxt     = (tick_count_nxt > cfg.timeout_ticks);
    on_nxt        = !((level_nxt < cfg.level_threshold) && !phase_nxt);
    out_valid_nxt = q_pop ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_index_r <= '0;
      tens_char_r  <= 8'd0;
      ones_char_r  <= 8'd0;
      tens_code_r  <= 4'd8;
      ones_code_r  <= BLANK_CODE;
      level_r      <= 7'd21;
      tick_count_r <= 8'd0;
      phase_r      <= 1'b1;
      out_valid_r  <= 1'b0;
    end else begin
      byte_index_r <= byte_index_nxt;
      tens_char_r  <= tens_char_nxt;
      ones_char_r  <= ones_char_nxt;
      tens_code_r  <= tens_code_nxt;
      ones_code_r  <= ones_code_nxt;
      level_r      <= level_nxt;
      tick_count_r <= tick_count_nxt;
      phase_r      <= phase_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_tens_seg_r <= seg_of(tens_code_nxt);
      out_ones_seg_r <= seg_of(ones_code_nxt);
      out_on_r       <= on_nxt;
      out_level_r    <= level_nxt;
      out_stale_r    <= stale_nxt;
      out_phase_r    <= phase_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_tens_segments = out_tens_seg_r;
  assign out_ones_segments = out_ones_seg_r;
  assign out_display_on    = out_on_r;
  assign out_level         = out_level_r;
  assign out_stale         = out_stale_r;
  assign out_blink_phase   = out_phase_r;

  `include "serial_frame_level_display_assert.svh"

  `SFLD_ASSERT_NEXT(a_byte_fresh, q_pop && !q_item.is_tick, !out_stale_r, "byte result marked stale")
  `SFLD_ASSERT_NEXT(a_marker_rewind, q_pop && q_item.is_marker, byte_index_r == '0, "index not rewound")
  `SFLD_ASSERT(a_code_legal, ((tens_code_r <= MAX_DIGIT) || (tens_code_r == BLANK_CODE)) && ((ones_code_r <= MAX_DIGIT) || (ones_code_r == BLANK_CODE)), "digit code out of set")
  `SFLD_ASSERT_NEXT(a_tick_phase, q_pop && q_item.is_tick, out_phase_r != $past(phase_r), "tick did not toggle phase")

endmodule

FILE: sim/serial_frame_level_display_tb.sv
// testbench for the serial frame level display: directed table, random frames, field checks
`timescale 1ns / 1ps

module serial_frame_level_display_tb;
  import sfld_pkg::*;

  // one displayed panel as the block reports it
  typedef struct packed {
    logic [6:0] tens_seg;
    logic [6:0] ones_seg;
    logic       disp_on;
    logic [6:0] level;
    logic       stale;
    logic       phase;
  } panel_t;

  // directed row: item plus an optional hand-typed panel
  typedef struct packed {
    logic       op;
    logic [7:0] value;
    logic       typed;
    panel_t     want;
  } stim_row_t;

  localparam int        STUCK_LIMIT  = 3000;
  localparam int        PHASES       = 8;
  localparam int        PHASE_ITEMS  = 170;
  localparam int        TICK_BURST   = 270;
  localparam int        HOLD_AT      = 500;
  localparam int        HOLD_CYCLES  = 80;
  localparam panel_t    NO_PANEL     = '0;
  localparam sfld_cfg_t CFG_DEFAULTS = '{8'd141, 8'd128, 6'd59, 6'd60, 7'd82, 8'd2};
  localparam logic [6:0] GLYPH [10] = '{7'h40, 7'h79, 7'h24, 7'h30, 7'h19,
                                        7'h12, 7'h02, 7'h78, 7'h00, 7'h10};

  // directed frames use positions 0 and 1 so that short frames decode
  localparam stim_row_t DIRECTED_ROWS [23] = '{
    '{OP_BYTE, 8'h00,  1'b1, '{7'h00, 7'h7F, 1'b1, 7'd21, 1'b0, 1'b1}},
    '{OP_TICK, 8'h00,  1'b1, '{7'h00, 7'h7F, 1'b0, 7'd21, 1'b0, 1'b0}},
    '{OP_TICK, 8'h5A,  1'b1, '{7'h00, 7'h7F, 1'b1, 7'd21, 1'b0, 1'b1}},
    '{OP_TICK, 8'hA5,  1'b1, '{7'h7F, 7'h7F, 1'b0, 7'd21, 1'b1, 1'b0}},
    '{OP_BYTE, 8'hFF,  1'b1, '{7'h7F, 7'h7F, 1'b0, 7'd21, 1'b0, 1'b0}},
    '{OP_BYTE, 8'd141, 1'b1, '{7'h7F, 7'h7F, 1'b0, 7'd21, 1'b0, 1'b0}},
    '{OP_BYTE, 8'hB9,  1'b0, NO_PANEL},
    '{OP_BYTE, 8'hB9,  1'b0, NO_PANEL},
    '{OP_BYTE, 8'd141, 1'b1, '{7'h10, 7'h10, 1'b1, 7'd99, 1'b0, 1'b0}},
    '{OP_BYTE, 8'hB0,  1'b0, NO_PANEL},
    '{OP_BYTE, 8'hB0,  1'b0, NO_PANEL},
    '{OP_BYTE, 8'd141, 1'b1, '{7'h40, 7'h40, 1'b0, 7'd0, 1'b0, 1'b0}},
    '{OP_TICK, 8'hFF,  1'b0, NO_PANEL},
    '{OP_BYTE, 8'hAF,  1'b0, NO_PANEL},
    '{OP_BYTE, 8'hBA,  1'b0, NO_PANEL},
    '{OP_BYTE, 8'd141, 1'b1, '{7'h7F, 7'h7F, 1'b1, 7'd0, 1'b0, 1'b1}},
    '{OP_BYTE, 8'hB8,  1'b0, NO_PANEL},
    '{OP_BYTE, 8'h80,  1'b0, NO_PANEL},
    '{OP_BYTE, 8'd141, 1'b0, NO_PANEL},
    '{OP_BYTE, 8'h2D,  1'b0, NO_PANEL},
    '{OP_TICK, 8'h33,  1'b0, NO_PANEL},
    '{OP_TICK, 8'hCC,  1'b0, NO_PANEL},
    '{OP_TICK, 8'h0F,  1'b0, NO_PANEL}
  };

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = CFG_END_MARKER;
  logic [7:0] cfg_wdata = 8'h00;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       in_opcode = OP_BYTE;
  logic [7:0] in_byte_value = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [6:0] out_tens_segments;
  logic [6:0] out_ones_segments;
  logic       out_display_on;
  logic [6:0] out_level;
  logic       out_stale;
  logic       out_blink_phase;

  // predictor copy of registers and state
  sfld_cfg_t        panel_cfg = CFG_DEFAULTS;
  logic [IDX_W-1:0] frame_idx = '0;
  logic [7:0]       tens_chr = 8'h00;
  logic [7:0]       ones_chr = 8'h00;
  logic [3:0]       tens_cd = 4'd8;
  logic [3:0]       ones_cd = BLANK_CODE;
  logic [6:0]       level_val = 7'd21;
  logic [7:0]       tick_cnt = 8'h00;
  logic             blink = 1'b1;

  panel_t panel_q [$];
  int     items_sent = 0;
  int     results_seen = 0;
  int     fail_count = 0;
  int     stuck = 0;
  int     hold_left = 0;
  logic   hold_done = 1'b0;
  logic   steady = 1'b0;

  serial_frame_level_display uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_byte_value     (in_byte_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_tens_segments (out_tens_segments),
    .out_ones_segments (out_ones_segments),
    .out_display_on    (out_display_on),
    .out_level         (out_level),
    .out_stale         (out_stale),
    .out_blink_phase   (out_blink_phase)
  );

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // active-low glyph for a digit code, blank above nine
  function automatic logic [6:0] glyph_of(input logic [3:0] code);
    if (code > MAX_DIGIT) return SEG_BLANK;
    return GLYPH[code];
  endfunction

  // advance the display state by one item and report the panel
  task automatic advance_panel(input logic op, input logic [7:0] b, output panel_t r);
    logic tens_ok;
    logic ones_ok;
    if (op == OP_BYTE) begin
      if (b != panel_cfg.end_marker) begin
        if (frame_idx < LAST_INDEX) begin
          if (frame_idx == panel_cfg.tens_position) tens_chr = b - panel_cfg.byte_offset;
          if (frame_idx == panel_cfg.ones_position) ones_chr = b - panel_cfg.byte_offset;
          frame_idx = frame_idx + IDX_W'(1);
        end
      end else begin
        tens_ok = (tens_chr >= CHAR_ZERO) && (tens_chr <= CHAR_NINE);
        ones_ok = (ones_chr >= CHAR_ZERO) && (ones_chr <= CHAR_NINE);
        tens_cd = tens_ok ? 4'(tens_chr - CHAR_ZERO) : BLANK_CODE;
        ones_cd = ones_ok ? 4'(ones_chr - CHAR_ZERO) : BLANK_CODE;
        if (tens_ok && ones_ok) level_val = 7'(int'(tens_cd) * 10 + int'(ones_cd));
        frame_idx = '0;
      end
      tick_cnt = 8'h00;
    end else begin
      blink = ~blink;
      if (tick_cnt != TICK_MAX) tick_cnt = tick_cnt + 8'd1;
      if (tick_cnt > panel_cfg.timeout_ticks) begin
        tens_cd = BLANK_CODE;
        ones_cd = BLANK_CODE;
      end
    end
    r.tens_seg = glyph_of(tens_cd);
    r.ones_seg = glyph_of(ones_cd);
    r.disp_on  = !((level_val < panel_cfg.level_threshold) && !blink);
    r.level    = level_val;
    r.stale    = tick_cnt > panel_cfg.timeout_ticks;
    r.phase    = blink;
  endtask

  // offer one item, wait for its transfer, then queue its panel
  task automatic send_item(input logic op, input logic [7:0] b, input logic typed,
                           input panel_t fixed);
    panel_t guess;
    while (!steady && $urandom_range(0, 99) < 38) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_opcode     <= op;
    in_byte_value <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_panel(op, b, guess);
    panel_q.push_back(typed ? fixed : guess);
    items_sent++;
    @(negedge clk);
  endtask

  // stop offering and let every queued panel come out
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (panel_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  // write all six registers back to back
  task automatic set_config(input sfld_cfg_t c);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_END_MARKER;
    cfg_wdata <= c.end_marker;
    @(negedge clk);
    cfg_index <= CFG_BYTE_OFFSET;
    cfg_wdata <= c.byte_offset;
    @(negedge clk);
    cfg_index <= CFG_TENS_POSITION;
    cfg_wdata <= 8'(c.tens_position);
    @(negedge clk);
    cfg_index <= CFG_ONES_POSITION;
    cfg_wdata <= 8'(c.ones_position);
    @(negedge clk);
    cfg_index <= CFG_LEVEL_THRESHOLD;
    cfg_wdata <= 8'(c.level_threshold);
    @(negedge clk);
    cfg_index <= CFG_TIMEOUT_TICKS;
    cfg_wdata <= c.timeout_ticks;
    @(negedge clk);
    cfg_we    <= 1'b0;
    panel_cfg = c;
  endtask

  // one frame with digits at the set positions, or a short burst of noise
  task automatic send_frame();
    int         top;
    int         span;
    int         trail;
    logic [7:0] ch;
    logic [7:0] b;
    if ($urandom_range(0, 7) == 0) begin
      repeat ($urandom_range(1, 8))
        send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'b0, NO_PANEL);
      return;
    end
    top = int'((panel_cfg.tens_position > panel_cfg.ones_position) ?
               panel_cfg.tens_position : panel_cfg.ones_position);
    span = (top >= 60 || $urandom_range(0, 9) == 0) ? $urandom_range(top + 1, 70) :
           top + 1 + $urandom_range(0, 2);
    for (int i = 0; i < span; i++) begin
      if ($urandom_range(0, 9) == 0) send_item(OP_TICK, 8'($urandom), 1'b0, NO_PANEL);
      if ((i == panel_cfg.tens_position || i == panel_cfg.ones_position) &&
          $urandom_range(0, 6) != 0)
        ch = CHAR_ZERO + 8'($urandom_range(0, 9));
      else
        ch = 8'($urandom);
      b = ch + panel_cfg.byte_offset;
      // a stray end marker inside the frame is kept only now and then
      if (b == panel_cfg.end_marker && $urandom_range(0, 3) != 0) b ^= 8'h01;
      send_item(OP_BYTE, b, 1'b0, NO_PANEL);
    end
    // a frame now and then loses its end marker
    if ($urandom_range(0, 11) != 0) send_item(OP_BYTE, panel_cfg.end_marker, 1'b0, NO_PANEL);
    // ticks after the frame, sometimes enough to go stale
    if ($urandom_range(0, 1) == 0) trail = $urandom_range(0, 2);
    else trail = (panel_cfg.timeout_ticks < 6) ? panel_cfg.timeout_ticks + 2 : 3;
    repeat (trail) send_item(OP_TICK, 8'($urandom), 1'b0, NO_PANEL);
  endtask

  // compare one field and count a mismatch
  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endtask

  // result side: random stall, plus one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !steady && ($urandom_range(0, 99) < 38);
    end
  end

  // check every result transfer against the oldest queued panel
  always @(posedge clk) begin
    panel_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (panel_q.size() == 0) begin
        $error("result transfer with no panel expected");
        fail_count++;
      end else begin
        want = panel_q.pop_front();
        check_field("tens_segments", 32'(want.tens_seg), 32'(out_tens_segments));
        check_field("ones_segments", 32'(want.ones_seg), 32'(out_ones_segments));
        check_field("display_on", 32'(want.disp_on), 32'(out_display_on));
        check_field("level", 32'(want.level), 32'(out_level));
        check_field("stale", 32'(want.stale), 32'(out_stale));
        check_field("blink_phase", 32'(want.phase), 32'(out_blink_phase));
      end
      results_seen++;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck <= 0;
    end else if (stuck >= STUCK_LIMIT) begin
      $display("serial_frame_level_display test failed");
      $finish;
    end else begin
      stuck <= stuck + 1;
    end
  end

  // stimulus
  initial begin
    sfld_cfg_t c;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed part, short frames at positions 0 and 1
    c = CFG_DEFAULTS;
    c.tens_position = 6'd0;
    c.ones_position = 6'd1;
    set_config(c);
    foreach (DIRECTED_ROWS[i])
      send_item(DIRECTED_ROWS[i].op, DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].typed,
                DIRECTED_ROWS[i].want);

    // random phases, each under its own register setting
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: c = CFG_DEFAULTS;
        1: c = '{8'd0, 8'd0, 6'd0, 6'd63, 7'd0, 8'd0};
        2: c = '{8'd255, 8'd255, 6'd62, 6'd62, 7'd100, 8'd255};
        3: c = '{8'd141, 8'd128, 6'd3, 6'd7, 7'd127, 8'd1};
        default: begin
          c.end_marker      = 8'($urandom);
          c.byte_offset     = 8'($urandom);
          c.tens_position   = $urandom_range(0, 1) ? 6'($urandom_range(0, 9)) : 6'($urandom);
          c.ones_position   = $urandom_range(0, 1) ? 6'($urandom_range(0, 9)) : 6'($urandom);
          c.level_threshold = 7'($urandom);
          c.timeout_ticks   = 8'($urandom_range(0, 6));
        end
      endcase
      steady = (p == 2);
      set_config(c);
      begin
        int start;
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS) send_frame();
      end
      // long tick run saturates the tick counter
      if (p == 2) repeat (TICK_BURST) send_item(OP_TICK, 8'($urandom), 1'b0, NO_PANEL);
    end

    wait_idle();
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("serial_frame_level_display test passed");
    else
      $display("serial_frame_level_display test failed");
    $finish;
  end

endmodule
